// File: design/mrp_pkg.sv
// ----------------------------------------------------------------------------
// mrp_pkg: shared types and constants of the material record parser
// Transaction payloads, parse phase codes, status codes and small helpers.
// ----------------------------------------------------------------------------
package mrp_pkg;

  // Width of the string length counter
  localparam int unsigned LENGTH_COUNTER_BITS = 21;

  // Result queue depth (holds the two results of the last record byte)
  localparam int unsigned OUT_DEPTH  = 4;
  localparam int unsigned OUT_PTR_W  = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

  // Parse phase codes
  localparam logic [4:0] PH_MAGIC   = 5'd0;
  localparam logic [4:0] PH_VERSION = 5'd1;
  localparam logic [4:0] PH_LEN0    = 5'd2;
  localparam logic [4:0] PH_LEN_END = 5'd13;
  localparam logic [4:0] PH_BASE    = 5'd14;
  localparam logic [4:0] PH_FLOAT0  = 5'd15;
  localparam logic [4:0] PH_EMIS    = 5'd18;
  localparam logic [4:0] PH_LIT     = 5'd19;
  localparam logic [4:0] PH_DSIDED  = 5'd20;
  localparam logic [4:0] PH_DRAIN   = 5'd21;

  // Status codes
  localparam logic [3:0] ST_FIELD     = 4'd0;
  localparam logic [3:0] ST_OK        = 4'd1;
  localparam logic [3:0] ST_NOTFMT    = 4'd2;
  localparam logic [3:0] ST_TRUNC_HDR = 4'd3;
  localparam logic [3:0] ST_VERSION   = 4'd4;
  localparam logic [3:0] ST_TRUNC     = 4'd5;
  localparam logic [3:0] ST_NEGLEN    = 4'd6;
  localparam logic [3:0] ST_BIGLEN    = 4'd7;
  localparam logic [3:0] ST_BOOL      = 4'd8;
  localparam logic [3:0] ST_BLANK     = 4'd9;
  localparam logic [3:0] ST_RANGE     = 4'd10;

  // Field indexes
  localparam logic [3:0] FI_BASE   = 4'd6;
  localparam logic [3:0] FI_FLOAT0 = 4'd7;
  localparam logic [3:0] FI_EMIS   = 4'd10;
  localparam logic [3:0] FI_LIT    = 4'd11;
  localparam logic [3:0] FI_DSIDED = 4'd12;

  // Register byte addresses
  localparam logic [2:0] ADDR_MAX_STRING = 3'd0;
  localparam logic [2:0] ADDR_VERSION    = 3'd4;

  // Register reset values
  localparam logic [20:0] MAX_STRING_RESET = 21'h100000;
  localparam logic [31:0] VERSION_RESET    = 32'd1;

  // Float range limits on raw bits
  localparam logic [31:0] FLOAT_ONE     = 32'h3F80_0000;
  localparam logic [31:0] FLOAT_NEG_ZERO = 32'h8000_0000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  field_index;
    logic [31:0] field_value;
    logic [3:0]  status;
    logic        last;
  } out_item_t;

  // Magic "WUMT", one byte per position
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h57;
      2'd1:    r = 8'h55;
      2'd2:    r = 8'h4D;
      2'd3:    r = 8'h54;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Field index that belongs to a phase from the first length onward
  function automatic logic [3:0] field_of(input logic [4:0] p);
    logic [3:0] r;
    logic [4:0] d;
    d = p - PH_LEN0;
    if (p >= PH_LEN0 && p <= PH_LEN_END) r = 4'(d >> 1);
    else if (p == PH_BASE) r = FI_BASE;
    else if (p >= PH_FLOAT0 && p < PH_EMIS) r = 4'(p - 5'd8);
    else if (p == PH_EMIS) r = FI_EMIS;
    else if (p == PH_LIT) r = FI_LIT;
    else r = FI_DSIDED;
    return r;
  endfunction

endpackage

// File: design/material_record_parser.sv
// ----------------------------------------------------------------------------
// material_record_parser: byte-serial parser for little-endian material records
// Checks magic and version, streams string bytes and scalar fields, and ends
// each record with one status result.
// ----------------------------------------------------------------------------
// The block takes one record byte per clock when not stalled. Each byte is
// decoded combinationally against the parse state and its results are pushed
// into a four-entry result queue, so input and output are decoupled. A string
// byte or a finished scalar field gives one result; the last byte of a valid
// record gives two (the double-sided flag and the final status), and in_stall_o
// rises whenever the queue has fewer than two free entries. With the output side
// never stalled the sustained rate is one byte per cycle. Each result is
// registered in the queue. The end-of-stream marker returns the parser to
// the start of a record. Registers: 0x0 max_string_bytes, 0x4 expected_version.
module material_record_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mrp_pkg::in_item_t   in_data_i,
  // Output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mrp_pkg::out_item_t  out_data_o,
  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned CW = mrp_pkg::LENGTH_COUNTER_BITS;

  // Configuration registers
  logic [20:0] max_string_q;
  logic [31:0] version_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_string_q <= mrp_pkg::MAX_STRING_RESET;
      version_q    <= mrp_pkg::VERSION_RESET;
    end else if (cfg_wr) begin
      if (paddr[2]) version_q <= pwdata;
      else          max_string_q <= pwdata[20:0];
    end
  end

  assign prdata = paddr[2] ? version_q : {11'd0, max_string_q};

  // Parse state
  logic [4:0]    phase_q, phase_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0]   word_q, word_d;
  logic [4:0]    nonblank_q, nonblank_d;
  logic [2:0]    rfail_q, rfail_d;

  // Result queue
  mrp_pkg::out_item_t             mem_q [mrp_pkg::OUT_DEPTH];
  logic [mrp_pkg::OUT_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [mrp_pkg::OUT_CNT_W-1:0]  count_q;
  logic                           in_acc, pop;
  logic [1:0]                     npush;
  mrp_pkg::out_item_t             res0, res1;

  assign in_stall_o  = count_q > mrp_pkg::OUT_CNT_W'(mrp_pkg::OUT_DEPTH - 2);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = count_q != '0;
  assign pop         = out_valid_o & ~out_stall_i;
  assign out_data_o  = mem_q[rd_ptr_q];

  // Per-byte decode
  logic [7:0]    b;
  logic [31:0]   word_nx;
  logic [CW-1:0] cnt_inc, cnt_dec;
  logic          take_done;
  logic [2:0]    s_len, s_body;
  logic [1:0]    fk;
  logic          is_blank_byte, float_bad, big_len;
  logic [3:0]    fin_st, fin_fi;
  logic [4:0]    d_len, d_body;

  always_comb begin
    b             = in_data_i.data_byte;
    word_nx       = {b, word_q[31:8]};
    cnt_inc       = cnt_q + 1'b1;
    cnt_dec       = cnt_q - 1'b1;
    take_done     = cnt_inc >= CW'(4);
    d_len         = phase_q - mrp_pkg::PH_LEN0;
    d_body        = phase_q - 5'd3;
    s_len         = 3'(d_len >> 1);
    s_body        = 3'(d_body >> 1);
    fk            = 2'(phase_q - mrp_pkg::PH_FLOAT0);
    is_blank_byte = (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
    float_bad     = !((word_nx <= mrp_pkg::FLOAT_ONE) ||
                      (word_nx == mrp_pkg::FLOAT_NEG_ZERO));
    big_len       = (word_nx > {11'd0, max_string_q}) || (|word_nx[31:CW]);

    // Final validation: first blank identity, then first bad float
    fin_st = mrp_pkg::ST_OK;
    fin_fi = 4'd0;
    for (int k = 2; k >= 0; k--) begin
      if (rfail_q[k]) begin
        fin_st = mrp_pkg::ST_RANGE;
        fin_fi = mrp_pkg::FI_FLOAT0 + 4'(k);
      end
    end
    for (int k = 4; k >= 0; k--) begin
      if (!nonblank_q[k]) begin
        fin_st = mrp_pkg::ST_BLANK;
        fin_fi = 4'(k);
      end
    end

    phase_d    = phase_q;
    cnt_d      = cnt_q;
    word_d     = word_q;
    nonblank_d = nonblank_q;
    rfail_d    = rfail_q;
    res0       = '0;
    res1       = '0;
    npush      = 2'd0;

    if (in_acc) begin
      if (in_data_i.end_of_stream) begin
        // Stream end: report not-format while idle, or truncation where a record is open, then restart
        res0.last = 1'b1;
        if (phase_q == mrp_pkg::PH_MAGIC) begin
          res0.status = mrp_pkg::ST_NOTFMT;
          npush       = 2'd1;
        end else if (phase_q == mrp_pkg::PH_VERSION) begin
          res0.status = mrp_pkg::ST_TRUNC_HDR;
          npush       = 2'd1;
        end else if (phase_q <= mrp_pkg::PH_DSIDED) begin
          res0.status      = mrp_pkg::ST_TRUNC;
          res0.field_index = mrp_pkg::field_of(phase_q);
          npush            = 2'd1;
        end
        phase_d    = mrp_pkg::PH_MAGIC;
        cnt_d      = '0;
        word_d     = '0;
        nonblank_d = '0;
        rfail_d    = '0;
      end else if (phase_q == mrp_pkg::PH_MAGIC) begin
        // Match the magic one byte at a time
        if (b != mrp_pkg::magic_byte(cnt_q[1:0])) begin
          res0.status = mrp_pkg::ST_NOTFMT;
          res0.last   = 1'b1;
          npush       = 2'd1;
          phase_d     = mrp_pkg::PH_DRAIN;
        end else if (take_done) begin
          phase_d = mrp_pkg::PH_VERSION;
          cnt_d   = '0;
          word_d  = '0;
        end else begin
          cnt_d  = cnt_inc;
          word_d = word_nx;
        end
      end else if (phase_q == mrp_pkg::PH_VERSION) begin
        // Assemble the version word and compare
        cnt_d  = cnt_inc;
        word_d = word_nx;
        if (take_done) begin
          if (word_nx != version_q) begin
            res0.status = mrp_pkg::ST_VERSION;
            res0.last   = 1'b1;
            npush       = 2'd1;
            phase_d     = mrp_pkg::PH_DRAIN;
          end else begin
            phase_d = mrp_pkg::PH_LEN0;
            cnt_d   = '0;
            word_d  = '0;
          end
        end
      end else if (phase_q <= mrp_pkg::PH_LEN_END && !phase_q[0]) begin
        // String length word
        cnt_d  = cnt_inc;
        word_d = word_nx;
        if (take_done) begin
          res0.field_index = 4'(s_len);
          res0.last        = 1'b1;
          if (word_nx[31]) begin
            res0.status = mrp_pkg::ST_NEGLEN;
            npush       = 2'd1;
            phase_d     = mrp_pkg::PH_DRAIN;
          end else if (big_len) begin
            res0.status = mrp_pkg::ST_BIGLEN;
            npush       = 2'd1;
            phase_d     = mrp_pkg::PH_DRAIN;
          end else if (word_nx == '0) begin
            phase_d = (s_len < 3'd5) ? 5'(phase_q + 5'd2) : mrp_pkg::PH_BASE;
            cnt_d   = '0;
            word_d  = '0;
          end else begin
            phase_d = phase_q + 5'd1;
            cnt_d   = word_nx[CW-1:0];
          end
        end
      end else if (phase_q <= mrp_pkg::PH_LEN_END) begin
        // String body: emit each byte, count down
        res0.field_index = 4'(s_body);
        res0.field_value = {24'd0, b};
        npush            = 2'd1;
        if (s_body < 3'd5 && !is_blank_byte) nonblank_d[s_body] = 1'b1;
        cnt_d = cnt_dec;
        if (cnt_dec == '0) begin
          phase_d = (s_body < 3'd5) ? 5'(phase_q + 5'd1) : mrp_pkg::PH_BASE;
          word_d  = '0;
        end
      end else if (phase_q <= mrp_pkg::PH_EMIS) begin
        // Colors and floats: emit the word when complete
        cnt_d  = cnt_inc;
        word_d = word_nx;
        if (take_done) begin
          res0.field_index = mrp_pkg::field_of(phase_q);
          res0.field_value = word_nx;
          npush            = 2'd1;
          if (phase_q >= mrp_pkg::PH_FLOAT0 && phase_q < mrp_pkg::PH_EMIS && float_bad) begin
            rfail_d[fk] = 1'b1;
          end
          phase_d = phase_q + 5'd1;
          cnt_d   = '0;
          word_d  = '0;
        end
      end else if (phase_q <= mrp_pkg::PH_DSIDED) begin
        // Boolean bytes; the last one closes the record
        res0.field_index = mrp_pkg::field_of(phase_q);
        npush            = 2'd1;
        if (b > 8'd1) begin
          res0.status = mrp_pkg::ST_BOOL;
          res0.last   = 1'b1;
          phase_d     = mrp_pkg::PH_DRAIN;
        end else begin
          res0.field_value = {31'd0, b[0]};
          if (phase_q == mrp_pkg::PH_LIT) begin
            phase_d = mrp_pkg::PH_DSIDED;
            cnt_d   = '0;
            word_d  = '0;
          end else begin
            res1.status      = fin_st;
            res1.field_index = fin_fi;
            res1.last        = 1'b1;
            npush            = 2'd2;
            phase_d          = mrp_pkg::PH_DRAIN;
          end
        end
      end else begin
        // Drop bytes after the final status
        phase_d = mrp_pkg::PH_DRAIN;
      end
    end
  end

  // Hold parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= mrp_pkg::PH_MAGIC;
      cnt_q      <= '0;
      word_q     <= '0;
      nonblank_q <= '0;
      rfail_q    <= '0;
    end else begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      word_q     <= word_d;
      nonblank_q <= nonblank_d;
      rfail_q    <= rfail_d;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + mrp_pkg::OUT_PTR_W'(npush);
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_q + mrp_pkg::OUT_CNT_W'(npush) - mrp_pkg::OUT_CNT_W'(pop);
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (npush != 2'd0) mem_q[wr_ptr_q] <= res0;
    if (npush == 2'd2) mem_q[wr_ptr_q + 1'b1] <= res1;
  end

endmodule

// File: design/mrp_checker.sv
// ----------------------------------------------------------------------------
// mrp_checker: port-level checks for the material record parser
// Watches the channels and the configuration port over time.
// ----------------------------------------------------------------------------
module mrp_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_o,
  input  mrp_pkg::in_item_t   in_data_i,
  input  logic                out_valid_o,
  input  logic                out_stall_i,
  input  mrp_pkg::out_item_t  out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic [31:0]         prdata,
  input  logic                pready
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // Accept input whenever no result is pending
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // Read back a written version register
  a_ver_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && paddr == mrp_pkg::ADDR_VERSION)
      ##1 (paddr == mrp_pkg::ADDR_VERSION && !(psel && penable && pwrite))
      |-> prdata == $past(pwdata))
    else $error("version register readback mismatch");

  // No result out of an empty block right after reset release
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result present after reset");

endmodule

bind material_record_parser mrp_checker u_mrp_checker (.*);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the material record parser
// Feeds record byte streams with random gaps on both handshakes, mirrors the
// parse in a cycle-free model, and checks every result field in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned ITEM_GOAL    = 1450;
  localparam int unsigned SETTINGS_N   = 6;
  localparam int unsigned SETTLE_GAP   = 8;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned PROBE_ROWS   = 23;
  localparam logic [7:0]  MAGIC_WORD [4] = '{8'h57, 8'h55, 8'h4D, 8'h54};
  localparam logic [7:0]  BLANK_CHARS [4] = '{8'h20, 8'h09, 8'h0D, 8'h0A};

  // Shapes of generated records; all but the clean one carry one defect
  typedef enum int {
    SHAPE_CLEAN, SHAPE_CUT, SHAPE_BAD_MAGIC, SHAPE_BAD_VERSION, SHAPE_NEG_LEN,
    SHAPE_BIG_LEN, SHAPE_BAD_BOOL, SHAPE_BLANK, SHAPE_FLOAT_OUT, SHAPE_IDLE_END
  } record_shape_e;

  // Directed row: byte, end marker and, where obvious, the final status
  typedef struct packed {
    bit         typed;
    logic [3:0] status;
    logic       eos;
    logic [7:0] data;
  } probe_row_t;

  probe_row_t probe_rows [PROBE_ROWS] = '{
    '{1'b1, mrp_pkg::ST_NOTFMT,    1'b1, 8'h00},  // end while idle
    '{1'b0, mrp_pkg::ST_FIELD,     1'b0, 8'h57},
    '{1'b1, mrp_pkg::ST_NOTFMT,    1'b0, 8'hFF},  // wrong second magic byte
    '{1'b0, mrp_pkg::ST_FIELD,     1'b0, 8'h00},  // ignored while draining
    '{1'b0, mrp_pkg::ST_FIELD,     1'b1, 8'hFF},  // end after status, silent
    '{1'b0, mrp_pkg::ST_FIELD,     1'b0, 8'h57},
    '{1'b0, mrp_pkg::ST_FIELD,     1'b0, 8'h55},
    '{1'b1, mrp_pkg::ST_NOTFMT,    1'b1, 8'hA5},  // end inside the magic
    '{1'b0, mrp_pkg::ST_FIELD,     1'b0, 8'h57},
    '{1'b0, mrp_pkg::ST_FIELD,     1'b0, 8'h55},
    '{1'b0, mrp_pkg::ST_FIELD,     1'b0, 8'h4D},
    '{1'b0, mrp_pkg::ST_FIELD,     1'b0, 8'h54},
    '{1'b0, mrp_pkg::ST_FIELD,     1'b0, 8'h01},
    '{1'b1, mrp_pkg::ST_TRUNC_HDR, 1'b1, 8'h5A},  // end inside the version
    '{1'b0, mrp_pkg::ST_FIELD,     1'b0, 8'h57},
    '{1'b0, mrp_pkg::ST_FIELD,     1'b0, 8'h55},
    '{1'b0, mrp_pkg::ST_FIELD,     1'b0, 8'h4D},
    '{1'b0, mrp_pkg::ST_FIELD,     1'b0, 8'h54},
    '{1'b0, mrp_pkg::ST_FIELD,     1'b0, 8'hFF},
    '{1'b0, mrp_pkg::ST_FIELD,     1'b0, 8'hFF},
    '{1'b0, mrp_pkg::ST_FIELD,     1'b0, 8'hFF},
    '{1'b1, mrp_pkg::ST_VERSION,   1'b0, 8'hFF},  // all-ones version
    '{1'b0, mrp_pkg::ST_FIELD,     1'b1, 8'h00}
  };

  // Block signals
  logic                 clk = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall_o;
  mrp_pkg::in_item_t    in_data = '0;
  logic                 out_valid_o;
  logic                 out_stall = 1'b0;
  mrp_pkg::out_item_t   out_data_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // Mirrored parse state and register copies
  logic [4:0]                              rec_phase = mrp_pkg::PH_MAGIC;
  logic [mrp_pkg::LENGTH_COUNTER_BITS-1:0] rec_count = '0;
  logic [31:0]                             rec_word = '0;
  logic [4:0]                              rec_nonblank = '0;
  logic [2:0]                              rec_badfloat = '0;
  logic [20:0]                             lim_len = mrp_pkg::MAX_STRING_RESET;
  logic [31:0]                             lim_ver = mrp_pkg::VERSION_RESET;

  mrp_pkg::out_item_t due_fields [$];
  logic [7:0]         stream_bytes [$];
  mrp_pkg::out_item_t got_field;
  mrp_pkg::out_item_t want_field;
  int unsigned mismatches = 0;
  int unsigned checked = 0;
  int unsigned pushed_fields = 0;
  int unsigned sent_items = 0;
  int unsigned records = 0;
  int unsigned settings_used = 1;
  int unsigned status_hits [16];
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  int unsigned stall_pick;
  logic        calm = 1'b0;

  material_record_parser dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Switch between stretches with and without idling
  always @(posedge clk) begin
    if ($urandom_range(0, 399) == 0) calm <= ~calm;
  end

  // Drive output stall: short bursts mostly, a long one now and then
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 55) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 6);
      end else if (stall_pick < 95) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(10, 40);
      end
    end
  end

  // Field index that a phase from the first length onward belongs to
  function automatic logic [3:0] phase_field(input logic [4:0] p);
    if (p <= mrp_pkg::PH_LEN_END) return 4'((p - mrp_pkg::PH_LEN0) >> 1);
    if (p == mrp_pkg::PH_BASE) return mrp_pkg::FI_BASE;
    if (p < mrp_pkg::PH_EMIS) return 4'(p - mrp_pkg::PH_FLOAT0) + mrp_pkg::FI_FLOAT0;
    if (p == mrp_pkg::PH_EMIS) return mrp_pkg::FI_EMIS;
    if (p == mrp_pkg::PH_LIT) return mrp_pkg::FI_LIT;
    return mrp_pkg::FI_DSIDED;
  endfunction

  function automatic void expect_field(input logic [3:0] fi, input logic [31:0] val,
                                       input logic [3:0] st, input logic last);
    mrp_pkg::out_item_t r;
    r.field_index = fi;
    r.field_value = val;
    r.status      = st;
    r.last        = last;
    due_fields.push_back(r);
    pushed_fields++;
  endfunction

  // Shift one byte into the little-endian word; true once four are in
  function automatic bit shift_byte(input logic [7:0] b);
    rec_word  = {b, rec_word[31:8]};
    rec_count = rec_count + 1'b1;
    return rec_count >= 4;
  endfunction

  function automatic void open_field(input logic [4:0] p);
    rec_phase = p;
    rec_count = '0;
    rec_word  = '0;
  endfunction

  function automatic void next_after_string(input int s);
    open_field(s < 5 ? 5'(mrp_pkg::PH_LEN0 + 2 * (s + 1)) : mrp_pkg::PH_BASE);
  endfunction

  function automatic void restart_record();
    open_field(mrp_pkg::PH_MAGIC);
    rec_nonblank = '0;
    rec_badfloat = '0;
  endfunction

  // Advance the mirrored parse by one accepted byte and queue its results
  function automatic void decode_byte(input mrp_pkg::in_item_t it);
    logic [7:0] b;
    logic [4:0] p;
    logic [3:0] st;
    logic [3:0] fi;
    int         s;
    int         k;
    b = it.data_byte;
    p = rec_phase;
    if (it.end_of_stream) begin
      if (p == mrp_pkg::PH_MAGIC)
        expect_field(4'd0, '0, mrp_pkg::ST_NOTFMT, 1'b1);
      else if (p == mrp_pkg::PH_VERSION)
        expect_field(4'd0, '0, mrp_pkg::ST_TRUNC_HDR, 1'b1);
      else if (p != mrp_pkg::PH_DRAIN)
        expect_field(phase_field(p), '0, mrp_pkg::ST_TRUNC, 1'b1);
      restart_record();
    end else if (p == mrp_pkg::PH_MAGIC) begin
      if (b != MAGIC_WORD[rec_count[1:0]]) begin
        expect_field(4'd0, '0, mrp_pkg::ST_NOTFMT, 1'b1);
        rec_phase = mrp_pkg::PH_DRAIN;
      end else if (shift_byte(b)) begin
        open_field(mrp_pkg::PH_VERSION);
      end
    end else if (p == mrp_pkg::PH_VERSION) begin
      if (shift_byte(b)) begin
        if (rec_word != lim_ver) begin
          expect_field(4'd0, '0, mrp_pkg::ST_VERSION, 1'b1);
          rec_phase = mrp_pkg::PH_DRAIN;
        end else begin
          open_field(mrp_pkg::PH_LEN0);
        end
      end
    end else if (p <= mrp_pkg::PH_LEN_END && !p[0]) begin
      // string length word
      s = (p - mrp_pkg::PH_LEN0) >> 1;
      if (shift_byte(b)) begin
        if (rec_word[31]) begin
          expect_field(4'(s), '0, mrp_pkg::ST_NEGLEN, 1'b1);
          rec_phase = mrp_pkg::PH_DRAIN;
        end else if (rec_word > 32'(lim_len) ||
                     (rec_word >> mrp_pkg::LENGTH_COUNTER_BITS) != 0) begin
          expect_field(4'(s), '0, mrp_pkg::ST_BIGLEN, 1'b1);
          rec_phase = mrp_pkg::PH_DRAIN;
        end else if (rec_word == 0) begin
          next_after_string(s);
        end else begin
          rec_phase = p + 5'd1;
          rec_count = rec_word[mrp_pkg::LENGTH_COUNTER_BITS-1:0];
        end
      end
    end else if (p <= mrp_pkg::PH_LEN_END) begin
      // string body: emit each byte, count down the rest
      s = (p - mrp_pkg::PH_LEN0 - 5'd1) >> 1;
      expect_field(4'(s), 32'(b), mrp_pkg::ST_FIELD, 1'b0);
      if (s < 5 && b != 8'h20 && b != 8'h09 && b != 8'h0D && b != 8'h0A)
        rec_nonblank[s] = 1'b1;
      rec_count = rec_count - 1'b1;
      if (rec_count == 0) next_after_string(s);
    end else if (p < mrp_pkg::PH_LIT) begin
      // colors and floats
      if (shift_byte(b)) begin
        expect_field(phase_field(p), rec_word, mrp_pkg::ST_FIELD, 1'b0);
        if (p >= mrp_pkg::PH_FLOAT0 && p < mrp_pkg::PH_EMIS &&
            !(rec_word <= mrp_pkg::FLOAT_ONE || rec_word == mrp_pkg::FLOAT_NEG_ZERO))
          rec_badfloat[p - mrp_pkg::PH_FLOAT0] = 1'b1;
        open_field(p + 5'd1);
      end
    end else if (p <= mrp_pkg::PH_DSIDED) begin
      // boolean bytes, then the record verdict
      if (b > 8'd1) begin
        expect_field(phase_field(p), '0, mrp_pkg::ST_BOOL, 1'b1);
        rec_phase = mrp_pkg::PH_DRAIN;
      end else begin
        expect_field(phase_field(p), 32'(b), mrp_pkg::ST_FIELD, 1'b0);
        if (p == mrp_pkg::PH_LIT) begin
          open_field(mrp_pkg::PH_DSIDED);
        end else begin
          st = mrp_pkg::ST_OK;
          fi = 4'd0;
          for (k = 0; k < 5; k++) begin
            if (st == mrp_pkg::ST_OK && !rec_nonblank[k]) begin
              st = mrp_pkg::ST_BLANK;
              fi = 4'(k);
            end
          end
          for (k = 0; k < 3; k++) begin
            if (st == mrp_pkg::ST_OK && rec_badfloat[k]) begin
              st = mrp_pkg::ST_RANGE;
              fi = mrp_pkg::FI_FLOAT0 + 4'(k);
            end
          end
          expect_field(fi, '0, st, 1'b1);
          rec_phase = mrp_pkg::PH_DRAIN;
        end
      end
    end else begin
      rec_phase = mrp_pkg::PH_DRAIN;
    end
  endfunction

  function automatic int unsigned input_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one transaction, hold it until accepted, then mirror it
  task automatic send_item(input logic [7:0] b, input logic eos);
    mrp_pkg::in_item_t it;
    int unsigned       gap;
    it.data_byte     = b;
    it.end_of_stream = eos;
    gap = input_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall_o);
    if (rec_phase != mrp_pkg::PH_DRAIN) sent_items++;
    decode_byte(it);
  endtask

  // Wait until every queued result is out and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (due_fields.size() != 0) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  // Setup and access cycle, then the bus goes idle
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == mrp_pkg::ADDR_MAX_STRING) lim_len = data[20:0];
    else lim_ver = data;
    @(posedge clk);
  endtask

  function automatic void append_word(input logic [31:0] w);
    stream_bytes.push_back(w[7:0]);
    stream_bytes.push_back(w[15:8]);
    stream_bytes.push_back(w[23:16]);
    stream_bytes.push_back(w[31:24]);
  endfunction

  // Build a record of the given shape; header and length defects stop the build early
  function automatic void build_record(input record_shape_e shape);
    logic [31:0] w;
    int          len;
    int          cap;
    int          victim;
    int          s;
    int          i;
    int          k;
    bit          blank;
    stream_bytes.delete();
    victim = $urandom_range(0, 5);
    for (i = 0; i < 4; i++) stream_bytes.push_back(MAGIC_WORD[i]);
    if (shape == SHAPE_BAD_MAGIC) begin
      k = $urandom_range(0, 3);
      stream_bytes[k] = stream_bytes[k] ^ 8'($urandom_range(1, 255));
      return;
    end
    w = lim_ver;
    if (shape == SHAPE_BAD_VERSION) begin
      if ($urandom_range(0, 1)) w = $urandom();
      else w = w ^ (32'h1 << $urandom_range(0, 31));
      append_word(w);
      return;
    end
    append_word(w);
    cap = (lim_len < 5) ? int'(lim_len) : 5;
    for (s = 0; s < 6; s++) begin
      if (shape == SHAPE_NEG_LEN && s == victim) begin
        append_word($urandom() | 32'h8000_0000);
        return;
      end
      if (shape == SHAPE_BIG_LEN && s == victim) begin
        w = $urandom() & 32'h7FFF_FFFF;
        if ($urandom_range(0, 1) || w <= 32'(lim_len)) w = 32'(lim_len) + 1;
        append_word(w);
        return;
      end
      len = $urandom_range((s < 5 && cap > 0) ? 1 : 0, cap);
      if (lim_len <= 8 && $urandom_range(0, 3) == 0) len = int'(lim_len);
      append_word(32'(len));
      blank = (shape == SHAPE_BLANK && s == victim % 5) || $urandom_range(0, 24) == 0;
      for (i = 0; i < len; i++) begin
        if (blank) stream_bytes.push_back(BLANK_CHARS[$urandom_range(0, 3)]);
        else stream_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    append_word($urandom());
    // roughness, metallic, specular: edges of the range, inside and outside
    for (k = 0; k < 3; k++) begin
      if ((shape == SHAPE_FLOAT_OUT && k == victim % 3) || $urandom_range(0, 29) == 0) begin
        case ($urandom_range(0, 4))
          0:       w = 32'h3F80_0001;
          1:       w = 32'h7F80_0000;
          2:       w = 32'hFFFF_FFFF;
          3:       w = 32'h8000_0001;
          default: w = $urandom() | 32'h4000_0000;
        endcase
      end else begin
        case ($urandom_range(0, 4))
          0:       w = 32'h0;
          1:       w = mrp_pkg::FLOAT_ONE;
          2:       w = mrp_pkg::FLOAT_NEG_ZERO;
          default: w = $urandom_range(0, mrp_pkg::FLOAT_ONE);
        endcase
      end
      append_word(w);
    end
    append_word($urandom());
    for (k = 0; k < 2; k++) begin
      if (shape == SHAPE_BAD_BOOL && k == victim % 2)
        stream_bytes.push_back(8'($urandom_range(2, 255)));
      else
        stream_bytes.push_back(8'($urandom_range(0, 1)));
    end
  endfunction

  // Pick a record shape, stream it and close it with an end marker
  task automatic run_record();
    record_shape_e shape;
    int unsigned   r;
    int            i;
    int            n;
    r = $urandom_range(0, 99);
    if (r < 38) shape = SHAPE_CLEAN;
    else if (r < 48) shape = SHAPE_CUT;
    else if (r < 55) shape = SHAPE_BAD_MAGIC;
    else if (r < 61) shape = SHAPE_BAD_VERSION;
    else if (r < 67) shape = SHAPE_NEG_LEN;
    else if (r < 73) shape = SHAPE_BIG_LEN;
    else if (r < 80) shape = SHAPE_BAD_BOOL;
    else if (r < 88) shape = SHAPE_BLANK;
    else if (r < 96) shape = SHAPE_FLOAT_OUT;
    else shape = SHAPE_IDLE_END;
    records++;
    if (shape == SHAPE_IDLE_END) begin
      send_item(8'($urandom_range(0, 255)), 1'b1);
      return;
    end
    build_record(shape);
    if (shape == SHAPE_CUT) begin
      n = $urandom_range(0, stream_bytes.size() - 1);
    end else begin
      repeat ($urandom_range(0, 2)) stream_bytes.push_back(8'($urandom_range(0, 255)));
      n = stream_bytes.size();
    end
    for (i = 0; i < n; i++) send_item(stream_bytes[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Check each transaction on the result side against the oldest expectation
  always @(posedge clk) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      got_field = out_data_o;
      if (due_fields.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected result idx %0d value %h status %0d last %0b",
                   $time, got_field.field_index, got_field.field_value,
                   got_field.status, got_field.last);
        mismatches++;
      end else begin
        want_field = due_fields.pop_front();
        checked++;
        if (got_field.last) status_hits[got_field.status]++;
        if (got_field.field_index !== want_field.field_index ||
            got_field.field_value !== want_field.field_value ||
            got_field.status !== want_field.status ||
            got_field.last !== want_field.last) begin
          if (mismatches < 10)
            $display("%0t: wrong result idx %0d/%0d value %h/%h status %0d/%0d last %0b/%0b",
                     $time, want_field.field_index, got_field.field_index,
                     want_field.field_value, got_field.field_value,
                     want_field.status, got_field.status, want_field.last, got_field.last);
          mismatches++;
        end
      end
    end
  end

  // Give up on a hung run
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("material_record_parser: mismatch");
    $finish;
  end

  initial begin
    int unsigned        setting;
    int unsigned        goal;
    int                 row;
    int unsigned        before_n;
    mrp_pkg::out_item_t typed_field;
    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Directed header cases
    for (row = 0; row < PROBE_ROWS; row++) begin
      before_n = pushed_fields;
      send_item(probe_rows[row].data, probe_rows[row].eos);
      if (probe_rows[row].typed) begin
        if (pushed_fields > before_n) void'(due_fields.pop_back());
        typed_field.field_index = 4'd0;
        typed_field.field_value = '0;
        typed_field.status      = probe_rows[row].status;
        typed_field.last        = 1'b1;
        due_fields.push_back(typed_field);
      end
    end
    goal = sent_items;

    // Random records under a sequence of register settings
    for (setting = 0; setting < SETTINGS_N; setting++) begin
      settle();
      case (setting)
        1: begin
          write_reg(mrp_pkg::ADDR_MAX_STRING, 32'd0);
          write_reg(mrp_pkg::ADDR_VERSION, 32'd0);
        end
        2: begin
          write_reg(mrp_pkg::ADDR_MAX_STRING, 32'(mrp_pkg::MAX_STRING_RESET));
          write_reg(mrp_pkg::ADDR_VERSION, 32'hFFFF_FFFF);
        end
        3: begin
          write_reg(mrp_pkg::ADDR_MAX_STRING, 32'd3);
          write_reg(mrp_pkg::ADDR_VERSION, $urandom());
        end
        4: begin
          write_reg(mrp_pkg::ADDR_MAX_STRING, $urandom_range(0, 40));
          write_reg(mrp_pkg::ADDR_VERSION, 32'd1);
        end
        5: begin
          write_reg(mrp_pkg::ADDR_MAX_STRING,
                    $urandom_range(0, 32'(mrp_pkg::MAX_STRING_RESET)));
          write_reg(mrp_pkg::ADDR_VERSION, $urandom());
        end
        default: ;
      endcase
      if (setting > 0) settings_used++;
      goal = goal + ITEM_GOAL / SETTINGS_N;
      while (sent_items < goal) run_record();
    end

    settle();
    $display("covered %0d records in %0d parsed bytes under %0d register settings",
             records, sent_items, settings_used);
    $display("checked %0d results: %0d accepted, %0d not format, %0d rejected records",
             checked, status_hits[mrp_pkg::ST_OK], status_hits[mrp_pkg::ST_NOTFMT],
             status_hits[mrp_pkg::ST_TRUNC_HDR] + status_hits[mrp_pkg::ST_VERSION] +
             status_hits[mrp_pkg::ST_TRUNC] + status_hits[mrp_pkg::ST_NEGLEN] +
             status_hits[mrp_pkg::ST_BIGLEN] + status_hits[mrp_pkg::ST_BOOL] +
             status_hits[mrp_pkg::ST_BLANK] + status_hits[mrp_pkg::ST_RANGE]);
    if (mismatches == 0 && due_fields.size() == 0) begin
      $display("material_record_parser: match");
    end else begin
      $display("material_record_parser: mismatch");
    end
    $finish;
  end

endmodule
